@@ design/rgb_convolution_3x3_macros.svh @@
// Assertion macros shared by the checker of the 3x3 RGB convolution block.
`ifndef RGB_CONVOLUTION_3X3_MACROS_SVH
`define RGB_CONVOLUTION_3X3_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define RGBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define RGBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Property checked at every edge, reset included.
`define RGBC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ design/rgbc_pkg.sv @@
// Types and constants shared by the 3x3 RGB convolution block.
`default_nettype none

package rgbc_pkg;

  localparam int NTAPS = 9;
  localparam int WEIGHT_W = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int FRAME_WIDTH_W = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int IN_ROW_W = FRAME_HEIGHT_W + 1;
  localparam int WEIGHTS_PER_REG = 4;

  localparam logic [7:0] CHANNEL_MAX = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_LOW = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_MID = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [CFG_DATA_W-1:0] WEIGHTS_LOW_RESET = 64'd0;
  localparam logic [CFG_DATA_W-1:0] WEIGHTS_MID_RESET = 64'd1024;
  localparam logic [WEIGHT_W-1:0] WEIGHTS_HIGH_RESET = 16'd0;
  localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd1024;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;
  } result_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } column_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } edges_t;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NTAPS-1:0] weight_set_t;
  typedef rgb_t [NTAPS-1:0] tap_array_t;

  typedef struct packed {
    logic       last;
    tap_array_t taps;
  } tap_set_t;

endpackage

`default_nettype wire

@@ design/rgb_convolution_3x3.sv @@
// Top level of the 3x3 RGB convolution block with clamp-to-edge borders.
// The pixel channel (pix_valid, pix_stall, pix) takes one transaction per cycle in raster
// order; pix.kind set marks a drain tick that flushes a pending result after the last
// pixel of a frame. A pixel sent while draining, or a drain tick sent mid-frame, is taken
// and dropped. The result channel (res_valid, res_stall, res) carries the filtered pixel,
// with frame_last on the final pixel of the frame. The result for a pixel appears one row
// and one pixel later in the stream, passing through the stage-1, window, tap, product,
// sum and result registers. Throughput is one transaction per cycle, set by the
// line-store port that is read and written once per transaction. Registers are written
// through cfg_we, cfg_index and cfg_data; the user must write them only while the block
// is idle, which the block does not enforce. Reset loads the register defaults, clears
// the counters, the window and the pipeline, and holds pix_stall high; the line stores
// are not cleared. When the receiver stalls, the result register holds and the pipeline
// keeps taking transactions until its stages fill, then raises pix_stall.
`default_nettype none

module rgb_convolution_3x3 #(
  parameter int MAX_WIDTH = 1024,
  parameter int WEIGHT_FRAC_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [rgbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rgbc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  pix_valid,
  output logic                                  pix_stall,
  input  rgbc_pkg::pixel_item_t                 pix,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output rgbc_pkg::result_item_t                res
);
  import rgbc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);

  logic [CFG_DATA_W-1:0]     weights_low;
  logic [CFG_DATA_W-1:0]     weights_mid;
  logic [WEIGHT_W-1:0]       weights_high;
  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  weight_set_t               wset;

  logic [WID_W-1:0]          w_eff;
  logic [FRAME_HEIGHT_W-1:0] h_eff;
  logic [FRAME_HEIGHT_W-1:0] h_last;

  logic [COL_W-1:0]          in_column;
  logic [IN_ROW_W-1:0]       in_row;
  logic [COL_W-1:0]          out_column;
  logic [FRAME_HEIGHT_W-1:0] out_row;

  logic   draining;
  logic   accept;
  logic   live;
  logic   emit;
  logic   col_wrap;
  edges_t edge_now;
  rgb_t   new_pix;

  logic             s1_valid;
  logic             s1_emit;
  logic             s1_byp;
  logic [COL_W-1:0] s1_col;
  rgb_t             s1_pix;
  rgb_t             s1_byp_older;
  rgb_t             s1_byp_newer;
  edges_t           s1_edges;
  rgb_t             older_rd;
  rgb_t             newer_rd;
  rgb_t             s1_older;
  rgb_t             s1_newer;
  logic             ready_1;
  logic             ready_w;
  logic             advance_1;

  logic       w_valid;
  edges_t     w_edges;
  column_t    feed_col;
  column_t    link_right;
  column_t    link_mid;
  column_t    view_left;
  column_t    view_mid;
  column_t    view_right;
  column_t    sel_col [3];
  tap_set_t   f_in;
  logic       f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights_low <= WEIGHTS_LOW_RESET;
      weights_mid <= WEIGHTS_MID_RESET;
      weights_high <= WEIGHTS_HIGH_RESET;
      frame_width <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHTS_LOW:  weights_low <= cfg_data;
        REG_WEIGHTS_MID:  weights_mid <= cfg_data;
        REG_WEIGHTS_HIGH: weights_high <= cfg_data[WEIGHT_W-1:0];
        REG_FRAME_WIDTH:  frame_width <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < WEIGHTS_PER_REG; k++) begin
      wset[k] = weights_low[WEIGHT_W*k +: WEIGHT_W];
      wset[WEIGHTS_PER_REG+k] = weights_mid[WEIGHT_W*k +: WEIGHT_W];
    end
    wset[NTAPS-1] = weights_high;
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width);
    end
    h_eff = (frame_height == '0) ? FRAME_HEIGHT_W'(1) : frame_height;
    h_last = h_eff - FRAME_HEIGHT_W'(1);
  end

  assign draining = in_row >= IN_ROW_W'(h_eff);
  assign accept = pix_valid && !pix_stall;
  assign live = accept && (pix.kind == draining);
  assign emit = (in_row >= IN_ROW_W'(2)) || (in_row == IN_ROW_W'(1) && in_column != '0);
  assign col_wrap = (WID_W'(in_column) + WID_W'(1)) >= w_eff;

  always_comb begin
    edge_now.top = out_row == '0;
    edge_now.bottom = out_row >= h_last;
    edge_now.left = out_column == '0;
    edge_now.right = (WID_W'(out_column) + WID_W'(1)) >= w_eff;
    edge_now.last = edge_now.bottom && edge_now.right;
  end

  always_comb begin
    if (pix.kind) begin
      new_pix = '0;
    end else begin
      new_pix.red = pix.in_red;
      new_pix.green = pix.in_green;
      new_pix.blue = pix.in_blue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      out_column <= '0;
      out_row <= '0;
    end else if (live) begin
      if (emit && edge_now.last) begin
        in_column <= '0;
        in_row <= '0;
        out_column <= '0;
        out_row <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          in_row <= in_row + IN_ROW_W'(1);
        end else begin
          in_column <= in_column + COL_W'(1);
        end
        if (emit) begin
          if (edge_now.right) begin
            out_column <= '0;
            out_row <= out_row + FRAME_HEIGHT_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
        end
      end
    end
  end

  assign ready_w = !w_valid || f_ready;
  assign ready_1 = !s1_valid || ready_w;
  assign advance_1 = s1_valid && ready_w;
  assign pix_stall = rst || !ready_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready_1) begin
      s1_valid <= live;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_1) begin
      s1_col <= in_column;
      s1_pix <= new_pix;
      s1_emit <= emit;
      s1_edges <= edge_now;
      s1_byp <= s1_valid && (s1_col == in_column);
      s1_byp_older <= s1_newer;
      s1_byp_newer <= s1_pix;
    end
  end

  assign s1_older = s1_byp ? s1_byp_older : older_rd;
  assign s1_newer = s1_byp ? s1_byp_newer : newer_rd;

  rgbc_line_store #(.DEPTH(MAX_WIDTH)) u_row_store_older (
    .clk     (clk),
    .wr_en   (advance_1),
    .wr_addr (s1_col),
    .wr_data (s1_newer),
    .rd_en   (live),
    .rd_addr (in_column),
    .rd_data (older_rd)
  );

  rgbc_line_store #(.DEPTH(MAX_WIDTH)) u_row_store_newer (
    .clk     (clk),
    .wr_en   (advance_1),
    .wr_addr (s1_col),
    .wr_data (s1_pix),
    .rd_en   (live),
    .rd_addr (in_column),
    .rd_data (newer_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (ready_w) begin
      w_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_w) begin
      w_edges <= s1_edges;
    end
  end

  always_comb begin
    feed_col.top = s1_older;
    feed_col.mid = s1_newer;
    feed_col.bot = s1_pix;
  end

  rgbc_cell u_cell_right (
    .clk   (clk),
    .rst   (rst),
    .shift (advance_1),
    .feed  (feed_col),
    .edges (w_edges),
    .pass  (link_right),
    .view  (view_right)
  );

  rgbc_cell u_cell_mid (
    .clk   (clk),
    .rst   (rst),
    .shift (advance_1),
    .feed  (link_right),
    .edges (w_edges),
    .pass  (link_mid),
    .view  (view_mid)
  );

  rgbc_cell u_cell_left (
    .clk   (clk),
    .rst   (rst),
    .shift (advance_1),
    .feed  (link_mid),
    .edges (w_edges),
    .pass  (),
    .view  (view_left)
  );

  always_comb begin
    sel_col[0] = w_edges.left ? view_mid : view_left;
    sel_col[1] = view_mid;
    sel_col[2] = w_edges.right ? view_mid : view_right;
    f_in.last = w_edges.last;
    for (int j = 0; j < 3; j++) begin
      f_in.taps[j] = sel_col[j].top;
      f_in.taps[3+j] = sel_col[j].mid;
      f_in.taps[6+j] = sel_col[j].bot;
    end
  end

  rgbc_filter #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_filter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (w_valid),
    .in_ready  (f_ready),
    .taps      (f_in),
    .weights   (wset),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ design/rgbc_line_store.sv @@
// One line store: a simple dual-port RAM with a registered read port.
`default_nettype none

module rgbc_line_store #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  rgbc_pkg::rgb_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output rgbc_pkg::rgb_t rd_data
);
  import rgbc_pkg::*;

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/rgbc_cell.sv @@
// Window cell: holds one column of three pixels and shows it with edge rows replicated.
`default_nettype none

module rgbc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  rgbc_pkg::column_t feed,
  input  rgbc_pkg::edges_t  edges,
  output rgbc_pkg::column_t pass,
  output rgbc_pkg::column_t view
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= '0;
    end else if (shift) begin
      pass <= feed;
    end
  end

  always_comb begin
    view.top = edges.top ? pass.mid : pass.top;
    view.mid = pass.mid;
    view.bot = edges.bottom ? pass.mid : pass.bot;
  end

endmodule

`default_nettype wire

@@ design/rgbc_filter.sv @@
// Weighting pipeline: registered taps, products, channel sums and clamped result register.
`default_nettype none

module rgbc_filter #(
  parameter int WEIGHT_FRAC_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rgbc_pkg::tap_set_t     taps,
  input  rgbc_pkg::weight_set_t  weights,
  output logic                   res_valid,
  input  logic                   res_stall,
  output rgbc_pkg::result_item_t res
);
  import rgbc_pkg::*;

  localparam int PROD_W = WEIGHT_W + 9;
  localparam int SUM_W = PROD_W + 4;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  logic     a_valid;
  tap_set_t a_taps;
  logic     b_valid;
  logic     b_last;
  prod_t    b_prod [3][NTAPS];
  prod_t    prod_next [3][NTAPS];
  logic     c_valid;
  logic     c_last;
  sum_t     c_sum [3];
  sum_t     sum_next [3];
  logic     ready_a;
  logic     ready_b;
  logic     ready_c;
  logic     ready_out;

  function automatic logic [7:0] chan_of(input rgb_t p, input int ch);
    logic [7:0] v;
    unique case (ch)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] clamp_channel(input sum_t s);
    logic [SUM_W-1:0] q;
    logic [7:0]       v;
    q = $unsigned(s) >> WEIGHT_FRAC_BITS;
    if (s[SUM_W-1] || s == '0) begin
      v = '0;
    end else if (q[SUM_W-1:8] != '0) begin
      v = CHANNEL_MAX;
    end else begin
      v = q[7:0];
    end
    return v;
  endfunction

  assign ready_out = !res_valid || !res_stall;
  assign ready_c = !c_valid || ready_out;
  assign ready_b = !b_valid || ready_c;
  assign ready_a = !a_valid || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < NTAPS; k++) begin
        prod_next[ch][k] = PROD_W'($signed({1'b0, chan_of(a_taps.taps[k], ch)})
                                   * $signed(weights[k]));
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int k = 0; k < NTAPS; k++) begin
        sum_next[ch] = sum_next[ch] + SUM_W'(b_prod[ch][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= in_valid;
      end
      if (ready_b) begin
        b_valid <= a_valid;
      end
      if (ready_c) begin
        c_valid <= b_valid;
      end
      if (ready_out) begin
        res_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_taps <= taps;
    end
    if (ready_b) begin
      b_last <= a_taps.last;
      b_prod <= prod_next;
    end
    if (ready_c) begin
      c_last <= b_last;
      c_sum <= sum_next;
    end
    if (ready_out) begin
      res.out_red <= clamp_channel(c_sum[0]);
      res.out_green <= clamp_channel(c_sum[1]);
      res.out_blue <= clamp_channel(c_sum[2]);
      res.frame_last <= c_last;
    end
  end

endmodule

`default_nettype wire

@@ design/rgbc_checker.sv @@
// Port-level checker for the 3x3 RGB convolution block and its bind statement.
`default_nettype none
`include "rgb_convolution_3x3_macros.svh"

module rgbc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   pix_valid,
  input logic                   pix_stall,
  input rgbc_pkg::pixel_item_t  pix,
  input logic                   res_valid,
  input logic                   res_stall,
  input rgbc_pkg::result_item_t res
);

  `RGBC_ASSERT_NEXT(res_held, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
  `RGBC_ASSERT_ALWAYS(reset_clears_result, rst |=> !res_valid, "result valid after reset")
  `RGBC_ASSERT_ALWAYS(reset_stalls_input, rst |-> pix_stall, "input taken during reset")
  `RGBC_ASSERT_NOW(empty_output_no_stall, !res_valid, !pix_stall, "input stalled with empty output")

endmodule

bind rgb_convolution_3x3 rgbc_checker u_checker (.*);

`default_nettype wire
